### design/dipv4_pkg.sv
package dipv4_pkg;

  // width of the part accumulator, wraps modulo 2^ACC_WIDTH
  localparam int unsigned ACC_WIDTH = 32;

  // stream widths
  localparam int unsigned CHAR_WIDTH = 8;
  localparam int unsigned OUT_WIDTH  = 8;

  // character codes
  localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_WIDTH-1:0] CH_DOT   = 8'h2e;
  localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_F  = 8'h66;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_F  = 8'h46;
  localparam logic [CHAR_WIDTH-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_WIDTH-1:0] CH_UP_X  = 8'h58;

  // limits on the last part for two, three and four parts, and on inner parts
  localparam logic [ACC_WIDTH-1:0] LIM_TWO   = ACC_WIDTH'(32'h00ff_ffff);
  localparam logic [ACC_WIDTH-1:0] LIM_THREE = ACC_WIDTH'(32'h0000_ffff);
  localparam logic [ACC_WIDTH-1:0] LIM_FOUR  = ACC_WIDTH'(32'h0000_00ff);
  localparam logic [ACC_WIDTH-1:0] LIM_INNER = ACC_WIDTH'(32'd255);

  // dot counts
  localparam logic [1:0] DOTS_ONE   = 2'd1;
  localparam logic [1:0] DOTS_TWO   = 2'd2;
  localparam logic [1:0] DOTS_THREE = 2'd3;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  // parser state carried from one character to the next
  typedef struct packed {
    logic [ACC_WIDTH-1:0] part_value;
    logic [1:0]           dots_seen;
    radix_e               radix_code;
    logic                 part_start;
    logic                 after_leading_zero;
    logic                 previous_was_dot;
    logic                 string_start;
    logic                 rejected;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    part_value:         '0,
    dots_seen:          2'd0,
    radix_code:         RADIX_DEC,
    part_start:         1'b1,
    after_leading_zero: 1'b0,
    previous_was_dot:   1'b0,
    string_start:       1'b1,
    rejected:           1'b0
  };

endpackage

### design/dipv4_parse.sv
module dipv4_parse import dipv4_pkg::*; (
  input  parse_state_t          state_i,
  input  logic [CHAR_WIDTH-1:0] char_i,
  output parse_state_t          state_o,
  output logic                  verdict_o
);

  logic                 is_digit;
  logic                 is_lower_hex;
  logic                 is_upper_hex;
  logic                 is_x;
  logic [3:0]           digit_val;
  logic [ACC_WIDTH-1:0] scaled;
  logic [ACC_WIDTH-1:0] accum;
  logic                 skip_prefix;

  // character classes
  always_comb begin
    is_digit     = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
    is_lower_hex = (char_i >= CH_LO_A) && (char_i <= CH_LO_F);
    is_upper_hex = (char_i >= CH_UP_A) && (char_i <= CH_UP_F);
    is_x         = (char_i == CH_LO_X) || (char_i == CH_UP_X);
    // letters a-f and A-F both carry 1..6 in the low nibble
    digit_val    = is_digit ? char_i[3:0] : char_i[3:0] + 4'd9;
  end

  // shift-add of the part value by the current radix
  always_comb begin
    case (state_i.radix_code)
      RADIX_HEX: scaled = state_i.part_value << 4;
      RADIX_OCT: scaled = state_i.part_value << 3;
      default:   scaled = (state_i.part_value << 3) + (state_i.part_value << 1);
    endcase
    accum = scaled + ACC_WIDTH'(digit_val);
  end

  // verdict for the string ending with this beat
  always_comb begin
    verdict_o = 1'b1;
    if (state_i.rejected || state_i.previous_was_dot) begin
      verdict_o = 1'b0;
    end else begin
      case (state_i.dots_seen)
        DOTS_ONE:   verdict_o = state_i.part_value <= LIM_TWO;
        DOTS_TWO:   verdict_o = state_i.part_value <= LIM_THREE;
        DOTS_THREE: verdict_o = state_i.part_value <= LIM_FOUR;
        default:    verdict_o = 1'b1;
      endcase
    end
  end

  // next parser state
  always_comb begin
    state_o     = state_i;
    skip_prefix = state_i.after_leading_zero && is_x;
    if (char_i == CH_NUL) begin
      state_o = PARSE_RESET;
    end else if (!state_i.rejected) begin
      state_o.after_leading_zero = 1'b0;
      if (skip_prefix) begin
        state_o.radix_code = RADIX_HEX;
      end else if (state_i.part_start && char_i == CH_ZERO) begin
        // leading zero opens an octal part
        state_o.part_start         = 1'b0;
        state_o.after_leading_zero = 1'b1;
        state_o.radix_code         = RADIX_OCT;
        state_o.part_value         = '0;
        state_o.previous_was_dot   = 1'b0;
        state_o.string_start       = 1'b0;
      end else if (is_digit ||
                   (state_i.radix_code == RADIX_HEX && (is_lower_hex || is_upper_hex))) begin
        state_o.part_value       = accum;
        state_o.part_start       = 1'b0;
        state_o.previous_was_dot = 1'b0;
        state_o.string_start     = 1'b0;
      end else if (char_i == CH_DOT) begin
        if (state_i.string_start || state_i.previous_was_dot ||
            state_i.part_value > LIM_INNER || state_i.dots_seen == DOTS_THREE) begin
          state_o.rejected = 1'b1;
        end else begin
          state_o.dots_seen        = state_i.dots_seen + 2'd1;
          state_o.part_value       = '0;
          state_o.radix_code       = RADIX_DEC;
          state_o.part_start       = 1'b1;
          state_o.previous_was_dot = 1'b1;
          state_o.string_start     = 1'b0;
        end
      end else begin
        state_o.rejected = 1'b1;
      end
    end
  end

endmodule

### design/dotted_ipv4_string_checker.sv
// verdict path: the zero byte of a string passes the input register, then the verdict register,
//   which it enters only once the output is free
// throughput: one character per cycle; a zero byte waits only while the verdict register
//   is still held by the downstream side
// reset: rst_ni clears the input and output valid flags and returns the parser to the
//   start of an empty string
module dotted_ipv4_string_checker import dipv4_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [CHAR_WIDTH-1:0] s_axis_tdata_i,  // [7:0] char_code
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_WIDTH-1:0]  m_axis_tdata_o   // [0] is_address, [7:1] zero
);

  logic                  in_valid_q;
  logic [CHAR_WIDTH-1:0] in_char_q;
  parse_state_t          state_q;
  parse_state_t          state_d;
  logic                  verdict;
  logic                  out_valid_q;
  logic                  out_addr_q;
  logic                  out_free;
  logic                  advance;
  logic                  is_end;

  // handshake control
  always_comb begin
    out_free        = !out_valid_q || m_axis_tready_i;
    is_end          = in_char_q == CH_NUL;
    advance         = in_valid_q && (!is_end || out_free);
    s_axis_tready_o = !in_valid_q || advance;
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_char_q <= s_axis_tdata_i;
    end
  end

  // character step
  dipv4_parse u_parse (
    .state_i   (state_q),
    .char_i    (in_char_q),
    .state_o   (state_d),
    .verdict_o (verdict)
  );

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PARSE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // verdict register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && is_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && advance && is_end) begin
      out_addr_q <= verdict;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_WIDTH-1){1'b0}}, out_addr_q};

endmodule

### design/dipv4_checker.sv
module dipv4_checker import dipv4_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [CHAR_WIDTH-1:0] s_axis_tdata_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_WIDTH-1:0]  m_axis_tdata_o
);

  // a stalled verdict beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("verdict beat changed while stalled");

  // padding bits stay clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_WIDTH-1:1] == '0)
    else $error("verdict padding not zero");

  // with the verdict register empty, the input side never stalls
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // no verdict straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("verdict valid right after reset");

endmodule

bind dotted_ipv4_string_checker dipv4_checker u_dipv4_checker (.*);
